FILE: src/dcrrc_pkg.sv
// Package for the daisy-chain read-all reply checker.
// Holds transfer payload types and shared constants; no dependencies.
package dcrrc_pkg;

  localparam int unsigned MAX_DEVICES_DEF = 32;
  localparam int unsigned CFG_W           = 6;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned DEV_IDX_W       = 5;
  localparam int unsigned HEADER_BYTES    = 4;

  localparam logic [CFG_W-1:0]  CHAIN_SIZE_RST = 6'd1;
  localparam logic [BYTE_W-1:0] CRC_POLY       = 8'hB2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              first_byte;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   device_value;
    logic [DEV_IDX_W-1:0] device_index;
    logic [BYTE_W-1:0]    register_address;
    logic [BYTE_W-1:0]    check_byte;
    logic                 status;
    logic                 last;
  } out_t;

endpackage

FILE: src/dcrrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcrrc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/daisy_chain_readall_response_checker_core.sv
// Read-all reply checker: parses reply bytes, runs a bit-serial CRC-8 and
// emits one result per device, or one error result on a CRC mismatch. Depends on dcrrc_pkg and dcrrc_ram.

// Each accepted reply byte before the PEC is taken in the transfer cycle and
// then fed through the bit-serial CRC-8 (reflected, poly 0xB2), which shifts
// one bit per cycle; the input is stalled meanwhile. Bytes after the PEC,
// until the next first_byte, are dropped without stalling the input. On a
// PEC match the device values are read back from the value RAM one at a time
// (RAM read, then output register load, which waits while the output is
// stalled); a mismatch gives one error result. The last result is held
// in the output register while the next byte is taken. chain_size is sampled
// per byte; 0 acts as 1 and values above MaxDevices saturate.
module daisy_chain_readall_response_checker_core #(
  parameter int unsigned MaxDevices = dcrrc_pkg::MAX_DEVICES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dcrrc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  dcrrc_pkg::in_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dcrrc_pkg::out_t             out_data_o
);

  localparam int unsigned PW  = $clog2(dcrrc_pkg::HEADER_BYTES + 2 * MaxDevices + 1);
  localparam int unsigned SW  = PW + dcrrc_pkg::CFG_W;
  localparam int unsigned AW  = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;
  localparam int unsigned BW  = dcrrc_pkg::BYTE_W;
  localparam int unsigned VW  = dcrrc_pkg::VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [dcrrc_pkg::CFG_W-1:0] cfg_q;
  logic [PW-1:0]               pos_q, pos_d;
  logic [BW-1:0]               crc_q, crc_d;
  logic [2:0]                  bit_q, bit_d;
  logic [BW-1:0]               low_q, low_d;
  logic [BW-1:0]               reg_q, reg_d;
  logic [BW-1:0]               chk_q, chk_d;
  logic                        err_q, err_d;
  logic [AW-1:0]               k_q, k_d;
  logic [AW-1:0]               lastk_q, lastk_d;
  logic                        out_valid_q, out_valid_d;
  dcrrc_pkg::out_t             out_q, out_d;

  logic [SW-1:0] n_s;
  logic [PW-1:0] n_dev, len, p, off;
  logic [BW-1:0] crc_base;
  logic          accept, out_free, is_last;
  logic          ram_we, ram_re;
  logic [VW-1:0] ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_last     = err_q || (k_q == lastk_q);

  always_comb begin
    n_s = SW'(cfg_q);
    if (n_s == '0) begin
      n_s = SW'(1);
    end
    if (n_s > SW'(MaxDevices)) begin
      n_s = SW'(MaxDevices);
    end
  end

  assign n_dev    = PW'(n_s);
  assign len      = (n_dev << 1) + PW'(dcrrc_pkg::HEADER_BYTES);
  assign p        = in_data_i.first_byte ? '0 : pos_q;
  assign crc_base = in_data_i.first_byte ? '0 : crc_q;
  assign off      = p - PW'(2);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    bit_d       = bit_q;
    low_d       = low_q;
    reg_d       = reg_q;
    chk_d       = chk_q;
    err_d       = err_q;
    k_d         = k_q;
    lastk_d     = lastk_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = p;
          crc_d = crc_base;
          if (p < len) begin
            if (p == len - PW'(1)) begin
              pos_d   = len;
              k_d     = '0;
              lastk_d = AW'(n_dev - PW'(1));
              if (in_data_i.rx_byte == crc_base) begin
                err_d   = 1'b0;
                state_d = S_RD;
              end else begin
                err_d   = 1'b1;
                state_d = S_OUT;
              end
            end else begin
              crc_d   = crc_base ^ in_data_i.rx_byte;
              bit_d   = '0;
              pos_d   = p + PW'(1);
              state_d = S_CRC;
              if (p == PW'(1)) begin
                reg_d = in_data_i.rx_byte;
              end else if (p >= PW'(2) && p < (n_dev << 1) + PW'(2)) begin
                if (!off[0]) begin
                  low_d = in_data_i.rx_byte;
                end else begin
                  ram_we = 1'b1;
                end
              end else if (p == (n_dev << 1) + PW'(2)) begin
                chk_d = in_data_i.rx_byte;
              end
            end
          end
        end
      end
      S_CRC: begin
        crc_d = crc_q[0] ? ((crc_q >> 1) ^ dcrrc_pkg::CRC_POLY) : (crc_q >> 1);
        bit_d = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.device_value     = err_q ? '0 : ram_rdata;
          out_d.device_index     = err_q ? '0 : dcrrc_pkg::DEV_IDX_W'(k_q);
          out_d.register_address = reg_q;
          out_d.check_byte       = chk_q;
          out_d.status           = err_q;
          out_d.last             = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= dcrrc_pkg::CHAIN_SIZE_RST;
      pos_q       <= '0;
      crc_q       <= '0;
      bit_q       <= '0;
      low_q       <= '0;
      reg_q       <= '0;
      chk_q       <= '0;
      err_q       <= 1'b0;
      k_q         <= '0;
      lastk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      bit_q       <= bit_d;
      low_q       <= low_d;
      reg_q       <= reg_d;
      chk_q       <= chk_d;
      err_q       <= err_d;
      k_q         <= k_d;
      lastk_q     <= lastk_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  dcrrc_ram #(
    .Width (VW),
    .Depth (MaxDevices)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (off[AW:1]),
    .wdata_i ({in_data_i.rx_byte, low_q}),
    .re_i    (ram_re),
    .raddr_i (k_q),
    .rdata_o (ram_rdata)
  );

  a_err_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.last && out_data_o.device_value == '0)
    else $error("error result not marked last or has nonzero value");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(dcrrc_pkg::HEADER_BYTES + 2 * MaxDevices))
    else $error("byte position beyond longest reply");

  a_ram_write_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> accept)
    else $error("value store written without an input transfer");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_OUT) |-> k_q <= lastk_q)
    else $error("result index past last device");

  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !is_last) |=> in_stall_o)
    else $error("input taken in the middle of a result burst");

endmodule
